@@ rtl/ued_pkg.sv @@
// Package for the unicode escape byte decoder.
// Holds character constants, the hex digit decoder and the command type that
// travels from the front end through the queue to the back end. No dependencies.
`default_nettype none

package ued_pkg;

   localparam int MAX_RESULTS = 6;
   localparam int CNT_W       = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0]  BACKSLASH       = 8'h5C;
   localparam logic [7:0]  LETTER_U        = 8'h75;
   localparam logic [7:0]  CHAR_0          = 8'h30;
   localparam logic [7:0]  CHAR_9          = 8'h39;
   localparam logic [7:0]  CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0]  CHAR_LOWER_F    = 8'h66;
   localparam logic [7:0]  CHAR_UPPER_A    = 8'h41;
   localparam logic [7:0]  CHAR_UPPER_F    = 8'h46;
   localparam logic [3:0]  HEX_LETTER_BASE = 4'd10;
   localparam logic [15:0] CODE_LIMIT      = 16'h00FF;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   // One accepted byte expands into up to six result bytes.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [CNT_W-1:0]            count;
      logic                        last;
   } cmd_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type r;
      r.valid = 1'b1;
      r.value = 4'd0;
      priority if (c >= CHAR_0 && c <= CHAR_9) begin
         r.value = c[3:0];
      end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
         r.value = 4'(c - CHAR_LOWER_A) + HEX_LETTER_BASE;
      end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
         r.value = 4'(c - CHAR_UPPER_A) + HEX_LETTER_BASE;
      end else begin
         r.valid = 1'b0;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/ued_front.sv @@
// Front end: tracks the escape state and turns each accepted byte into a
// command listing the bytes it produces. Depends on ued_pkg.
`default_nettype none

module ued_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire logic [7:0]       in_byte,
   input  wire logic             in_final,
   output ued_pkg::cmd_type      cmd,
   output logic                  cmd_push
);

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_BSL  = 6'b000010,
      ST_UESC = 6'b000100,
      ST_DIG1 = 6'b001000,
      ST_DIG2 = 6'b010000,
      ST_DIG3 = 6'b100000
   } state_type;

   state_type         state_ff, state_in, state_next;
   logic [3:0][7:0]   held_ff, held_in;
   logic [11:0]       code_ff, code_in;

   // Number of bytes held by a pending escape in the given state.
   function automatic logic [2:0] held_count(input state_type s);
      logic [2:0] n;
      n = 3'd0;
      unique case (s)
         ST_IDLE: n = 3'd0;
         ST_BSL:  n = 3'd1;
         ST_UESC: n = 3'd2;
         ST_DIG1: n = 3'd3;
         ST_DIG2: n = 3'd4;
         ST_DIG3: n = 3'd5;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   always_comb begin
      ued_pkg::hex_type                        hex;
      logic [15:0]                             code16;
      logic [2:0]                              k1, k2, pos, j;
      logic                                    hx;
      logic [7:0]                              x;
      logic [ued_pkg::MAX_RESULTS-1:0][7:0]    hist;

      hex        = ued_pkg::hex_decode(in_byte);
      code16     = {code_ff, hex.value};
      k1         = 3'd0;
      hx         = 1'b0;
      x          = in_byte;
      state_next = state_ff;
      held_in    = held_ff;
      code_in    = code_ff;

      unique case (state_ff)
         ST_BSL: begin
            if (in_byte == ued_pkg::LETTER_U) begin
               state_next = ST_UESC;
               code_in    = 12'd0;
            end else begin
               k1 = 3'd1;
               if (in_byte == ued_pkg::BACKSLASH) begin
                  state_next = ST_BSL;
               end else begin
                  hx         = 1'b1;
                  state_next = ST_IDLE;
               end
            end
         end
         ST_UESC, ST_DIG1, ST_DIG2, ST_DIG3: begin
            if (hex.valid) begin
               held_in[2'(held_count(state_ff) - 3'd2)] = in_byte;
               code_in = code16[11:0];
               unique case (state_ff)
                  ST_UESC: state_next = ST_DIG1;
                  ST_DIG1: state_next = ST_DIG2;
                  ST_DIG2: state_next = ST_DIG3;
                  default: begin
                     // Fourth digit completes the escape.
                     state_next = ST_IDLE;
                     if (code16 <= ued_pkg::CODE_LIMIT) begin
                        hx = 1'b1;
                        x  = code16[7:0];
                     end else begin
                        k1 = 3'd6;
                     end
                  end
               endcase
            end else begin
               // The held bytes go out as text, then the byte is seen from idle.
               k1 = held_count(state_ff);
               if (in_byte == ued_pkg::BACKSLASH) begin
                  state_next = ST_BSL;
               end else begin
                  hx         = 1'b1;
                  state_next = ST_IDLE;
               end
            end
         end
         default: begin
            if (in_byte == ued_pkg::BACKSLASH) begin
               state_next = ST_BSL;
            end else begin
               hx         = 1'b1;
               state_next = ST_IDLE;
            end
         end
      endcase

      k2       = in_final ? held_count(state_next) : 3'd0;
      state_in = (accept && in_final) ? ST_IDLE : (accept ? state_next : state_ff);
      if (!accept) begin
         held_in = held_ff;
         code_in = code_ff;
      end

      hist = {held_in[3], held_in[2], held_in[1], held_in[0],
              ued_pkg::LETTER_U, ued_pkg::BACKSLASH};

      for (int i = 0; i < ued_pkg::MAX_RESULTS; i++) begin
         pos = 3'(i);
         j   = pos - k1 - {2'b00, hx};
         if (pos < k1) begin
            cmd.bytes[i] = hist[pos];
         end else if (hx && pos == k1) begin
            cmd.bytes[i] = x;
         end else if (j < 3'd6) begin
            cmd.bytes[i] = hist[j];
         end else begin
            cmd.bytes[i] = ued_pkg::BACKSLASH;
         end
      end
      cmd.count = k1 + {2'b00, hx} + k2;
      cmd.last  = in_final;
      cmd_push  = accept && (cmd.count != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      held_ff <= held_in;
      code_ff <= code_in;
   end

endmodule

`default_nettype wire

@@ rtl/ued_queue.sv @@
// Command queue between the front end and the back end.
// Small register FIFO of ued_pkg::cmd_type entries. Depends on ued_pkg.
`default_nettype none

module ued_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire ued_pkg::cmd_type  push_cmd,
   input  wire logic              pop,
   output ued_pkg::cmd_type       head_cmd,
   output logic                   head_valid,
   output logic                   full
);

   ued_pkg::cmd_type                   entry_ff [ued_pkg::QUEUE_DEPTH];
   logic [ued_pkg::QPTR_W-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [ued_pkg::QPTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [ued_pkg::QCNT_W-1:0]         count_ff, count_in;

   assign full       = (count_ff == ued_pkg::QCNT_W'(ued_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + ued_pkg::QCNT_W'(push) - ued_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

@@ rtl/ued_back.sv @@
// Back end: walks the bytes of the queue head, one result transaction per cycle
// while rsp_ready is high, and pops it after its last byte. Depends on ued_pkg.
`default_nettype none

module ued_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire ued_pkg::cmd_type  head_cmd,
   input  wire logic              head_valid,
   output logic                   pop,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_out_final
);

   logic [ued_pkg::CNT_W-1:0] idx_ff, idx_in;
   logic                      at_last;

   always_comb begin
      at_last       = (idx_ff == head_cmd.count - 1'b1);
      rsp_valid     = head_valid;
      rsp_out_byte  = (idx_ff < 3'd6) ? head_cmd.bytes[idx_ff] : ued_pkg::BACKSLASH;
      rsp_out_final = head_cmd.last && at_last;
      pop           = head_valid && rsp_ready && at_last;
      if (pop) begin
         idx_in = '0;
      end else if (head_valid && rsp_ready) begin
         idx_in = idx_ff + 1'b1;
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/unicode_escape_byte_decoder_top.sv @@
// Unicode escape byte decoder, top level.
// An accepted byte's command is registered in the command queue before its first
// result goes out. Throughput: one input byte per cycle while each byte yields
// at most one result and rsp_ready is high; a byte that yields several results
// holds the output side while they go out; a four-entry command queue absorbs
// them. Synchronous reset empties the queue and idles the escape tracker.
`default_nettype none

module unicode_escape_byte_decoder_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_in_final,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_out_final
);

   ued_pkg::cmd_type push_cmd, head_cmd;
   logic             push, pop, head_valid, full, accept;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   ued_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_in_byte),
      .in_final (req_in_final),
      .cmd      (push_cmd),
      .cmd_push (push)
   );

   ued_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid),
      .full       (full)
   );

   ued_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_cmd      (head_cmd),
      .head_valid    (head_valid),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_final (rsp_out_final)
   );

`ifndef SYNTHESIS
   // A final byte always leaves at least one result behind it.
   a_final_yields: assert property (@(posedge clock) disable iff (reset)
      (accept && req_in_final) |-> push)
      else $error("final transaction produced no result");

   // Commands in the queue carry between one and six bytes.
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      head_valid |-> (head_cmd.count != 3'd0 && head_cmd.count <= 3'd6))
      else $error("queue head has a bad byte count");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("command pushed into a full queue");
`endif

endmodule

`default_nettype wire

@@ tb/sv/unicode_escape_byte_decoder_top_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for unicode_escape_byte_decoder_top.
// Depends on ued_pkg for the character constants; predicts every output byte
// and compares it against the design through valid/ready handshakes.

module unicode_escape_byte_decoder_top_test;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 355;
   localparam int DRAIN_CYCLES   = 16;

   localparam logic [2:0] ESC_IDLE       = 3'd0;
   localparam logic [2:0] ESC_SLASH      = 3'd1;
   localparam logic [2:0] ESC_U          = 3'd2;
   localparam logic [2:0] ESC_LAST_DIGIT = 3'd5;
   localparam logic [2:0] ESC_COMPLETE   = 3'd6;

   typedef struct packed {
      logic [7:0] text;
      logic       last;
   } text_out_type;

   typedef enum int {TOK_ESCAPE, TOK_WIDE, TOK_CUT, TOK_TEXT, TOK_NOISE} token_kind_type;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte   = 8'h00;
   logic       req_in_final  = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready     = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_out_final;

   // Decoder state as the testbench tracks it.
   logic [2:0]  esc_state = ESC_IDLE;
   logic [7:0]  digit_buf [0:3];
   logic [15:0] code_acc  = 16'h0000;

   text_out_type expected_text [$];
   logic [7:0]   str_bytes [$];

   int  errors      = 0;
   int  n_items     = 0;
   int  n_strings   = 0;
   int  n_results   = 0;
   int  n_decoded   = 0;
   int  stall_left  = 0;
   int  quiet_cycles = 0;
   bit  steady      = 1'b0;

   unicode_escape_byte_decoder_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .req_in_final  (req_in_final),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_final (rsp_out_final)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= ued_pkg::CHAR_0 && c <= ued_pkg::CHAR_9) return int'(c - ued_pkg::CHAR_0);
      if (c >= ued_pkg::CHAR_LOWER_A && c <= ued_pkg::CHAR_LOWER_F)
         return int'(c - ued_pkg::CHAR_LOWER_A) + 10;
      if (c >= ued_pkg::CHAR_UPPER_A && c <= ued_pkg::CHAR_UPPER_F)
         return int'(c - ued_pkg::CHAR_UPPER_A) + 10;
      return -1;
   endfunction

   task automatic expect_text(input logic [7:0] b);
      expected_text.push_back('{text: b, last: 1'b0});
   endtask

   // Give back whatever part of an escape is still held, as plain text.
   task automatic release_escape();
      int i;
      if (esc_state >= ESC_SLASH && esc_state <= ESC_COMPLETE) expect_text(ued_pkg::BACKSLASH);
      if (esc_state >= ESC_U && esc_state <= ESC_COMPLETE) begin
         expect_text(ued_pkg::LETTER_U);
         for (i = 0; i + 2 < int'(esc_state) && i < 4; i++) expect_text(digit_buf[i]);
      end
      esc_state = ESC_IDLE;
   endtask

   task automatic take_idle(input logic [7:0] b);
      if (b == ued_pkg::BACKSLASH) begin
         esc_state = ESC_SLASH;
      end else begin
         esc_state = ESC_IDLE;
         expect_text(b);
      end
   endtask

   task automatic predict_decode(input logic [7:0] b, input logic fin);
      int           nib;
      int           first;
      text_out_type tail;
      first = expected_text.size();
      if (esc_state == ESC_SLASH) begin
         if (b == ued_pkg::LETTER_U) begin
            esc_state = ESC_U;
            code_acc  = 16'h0000;
         end else begin
            expect_text(ued_pkg::BACKSLASH);
            take_idle(b);
         end
      end else if (esc_state >= ESC_U && esc_state <= ESC_LAST_DIGIT) begin
         nib = nibble_of(b);
         if (nib >= 0) begin
            digit_buf[int'(esc_state) - 2] = b;
            code_acc  = {code_acc[11:0], 4'(nib)};
            esc_state = esc_state + 3'd1;
            if (esc_state == ESC_COMPLETE) begin
               if (code_acc <= ued_pkg::CODE_LIMIT) begin
                  expect_text(code_acc[7:0]);
                  esc_state = ESC_IDLE;
                  n_decoded++;
               end else begin
                  release_escape();
               end
            end
         end else begin
            release_escape();
            take_idle(b);
         end
      end else begin
         take_idle(b);
      end
      if (fin) begin
         release_escape();
         if (expected_text.size() > first) begin
            tail = expected_text.pop_back();
            tail.last = 1'b1;
            expected_text.push_back(tail);
         end
      end
   endtask

   // ---------------------------------------------------------------- sender side

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 30);
   endfunction

   // Valid is only lowered when a gap follows, so it never drops and rises
   // again within one time step.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_in_byte  <= b;
      req_in_final <= fin;
      do @(posedge clock); while (!req_ready);
      predict_decode(b, fin);
      n_items++;
   endtask

   task automatic send_string();
      int i;
      for (i = 0; i < str_bytes.size(); i++) send_byte(str_bytes[i], i == str_bytes.size() - 1);
      n_strings++;
   endtask

   task automatic send_text(input string s);
      int i;
      str_bytes.delete();
      for (i = 0; i < s.len(); i++) str_bytes.push_back(s[i]);
      send_string();
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_text.size() != 0) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- receiver side

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (steady || $urandom_range(0, 99) < 70) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready  <= 1'b0;
         stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      end
   end

   always @(posedge clock) begin
      text_out_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         n_results++;
         if (expected_text.size() == 0) begin
            errors++;
            $display("%0t ns: unexpected transaction, expected none, got byte %h final %b",
                     $time, rsp_out_byte, rsp_out_final);
         end else begin
            want = expected_text.pop_front();
            if (rsp_out_byte !== want.text) begin
               errors++;
               $display("%0t ns: out_byte expected %h, got %h", $time, want.text, rsp_out_byte);
            end
            if (rsp_out_final !== want.last) begin
               errors++;
               $display("%0t ns: out_final expected %b, got %b", $time, want.last, rsp_out_final);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no transaction for %0d cycles, %0d results outstanding",
                  $time, WATCHDOG_LIMIT, expected_text.size());
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- string builder

   function automatic logic [7:0] hex_char(input int v, input bit upper);
      if (v < 10) return ued_pkg::CHAR_0 + 8'(v);
      return (upper ? ued_pkg::CHAR_UPPER_A : ued_pkg::CHAR_LOWER_A) + 8'(v - 10);
   endfunction

   task automatic push_escape(input int d0, input int d1, input int d2, input int d3);
      str_bytes.push_back(ued_pkg::BACKSLASH);
      str_bytes.push_back(ued_pkg::LETTER_U);
      str_bytes.push_back(hex_char(d0, $urandom_range(0, 1)));
      str_bytes.push_back(hex_char(d1, $urandom_range(0, 1)));
      str_bytes.push_back(hex_char(d2, $urandom_range(0, 1)));
      str_bytes.push_back(hex_char(d3, $urandom_range(0, 1)));
   endtask

   function automatic logic [7:0] pick_breaker();
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return ued_pkg::BACKSLASH;
      if (r == 1) return ued_pkg::LETTER_U;
      if (r == 2) return 8'h67 + 8'($urandom_range(0, 18));   // lowercase past 'f'
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic push_token(input token_kind_type kind);
      int d0;
      int d1;
      int k;
      int i;
      case (kind)
         TOK_ESCAPE: begin
            push_escape(0, 0, $urandom_range(0, 15), $urandom_range(0, 15));
         end
         TOK_WIDE: begin
            d0 = $urandom_range(0, 15);
            d1 = (d0 == 0) ? $urandom_range(1, 15) : $urandom_range(0, 15);
            push_escape(d0, d1, $urandom_range(0, 15), $urandom_range(0, 15));
         end
         TOK_CUT: begin
            // A backslash, maybe 'u', up to three digits, then maybe a breaker.
            k = $urandom_range(0, 4);
            str_bytes.push_back(ued_pkg::BACKSLASH);
            if (k >= 1) str_bytes.push_back(ued_pkg::LETTER_U);
            for (i = 1; i < k; i++) str_bytes.push_back(hex_char($urandom_range(0, 15),
                                                                 $urandom_range(0, 1)));
            if ($urandom_range(0, 1)) str_bytes.push_back(pick_breaker());
         end
         TOK_TEXT: begin
            k = $urandom_range(1, 3);
            for (i = 0; i < k; i++) str_bytes.push_back(8'($urandom_range(0, 255)));
         end
         default: begin
            k = $urandom_range(1, 4);
            for (i = 0; i < k; i++) begin
               if ($urandom_range(0, 1)) str_bytes.push_back(pick_breaker());
               else str_bytes.push_back(hex_char($urandom_range(0, 15), $urandom_range(0, 1)));
            end
         end
      endcase
   endtask

   function automatic token_kind_type pick_token();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return TOK_ESCAPE;
      if (r < 55) return TOK_WIDE;
      if (r < 72) return TOK_CUT;
      if (r < 90) return TOK_TEXT;
      return TOK_NOISE;
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_plain_bytes();
      str_bytes = '{8'h00, 8'hFF, 8'h41};
      send_string();
   endtask

   task automatic test_decoded_escape();
      send_text("\\u00Ff");
   endtask

   task automatic test_wide_value();
      send_text("\\u0100");
   endtask

   task automatic test_broken_escapes();
      steady = 1'b1;
      str_bytes = '{ued_pkg::BACKSLASH, 8'h71};
      foreach (str_bytes[i]) send_byte(str_bytes[i], 1'b0);
      // A backslash inside an escape restarts it; the 'x' then breaks that one too.
      send_text("\\u0\\x");
      steady = 1'b0;
   endtask

   task automatic test_truncated_end();
      send_text("\\u4");
   endtask

   task automatic test_random_strings();
      int start;
      int tokens;
      int t;
      bit paused;
      start  = n_items;
      paused = 1'b0;
      while (n_items - start < RANDOM_ITEMS) begin
         steady = ($urandom_range(0, 4) == 0);
         str_bytes.delete();
         tokens = $urandom_range(1, 4);
         for (t = 0; t < tokens; t++) push_token(pick_token());
         send_string();
         if (!paused && n_items - start >= RANDOM_ITEMS / 2) begin
            hold_until_drained();
            paused = 1'b1;
         end
      end
      steady = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_bytes();
      test_decoded_escape();
      test_wide_value();
      test_broken_escapes();
      test_truncated_end();
      test_random_strings();

      hold_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_text.size() != 0) begin
         errors++;
         $display("%0t ns: %0d results expected, none arrived", $time, expected_text.size());
      end

      $display("Sent %0d bytes in %0d strings, checked %0d output bytes.",
               n_items, n_strings, n_results);
      $display("Escapes decoded to a byte: %0d; errors seen: %0d.", n_decoded, errors);
      if (errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

@@ unicode_escape_byte_decoder_top.f @@
rtl/ued_pkg.sv
rtl/ued_front.sv
rtl/ued_queue.sv
rtl/ued_back.sv
rtl/unicode_escape_byte_decoder_top.sv
tb/sv/unicode_escape_byte_decoder_top_test.sv
